### design/tfn_pkg.sv
package tfn_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned EDGE_W  = 17;
  localparam int unsigned PROD_W  = 34;
  localparam int unsigned CROSS_W = 35;
  localparam int unsigned MAG_W   = 34;
  localparam int unsigned SQ_W    = 68;
  localparam int unsigned SUM_W   = 70;
  localparam int unsigned RHS_W   = 98;
  localparam int unsigned ACC_W   = 104;
  localparam int unsigned Q_W     = 15;
  localparam int unsigned LEN_W   = 35;
  localparam int unsigned NUM_STEPS = 15;
  localparam logic [LEN_W-1:0] LEN_RESET = 35'd17;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [EDGE_W-1:0]  edge_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [CROSS_W-1:0] cross_t;
  typedef logic [MAG_W-1:0]          mag_t;
  typedef logic [SQ_W-1:0]           sq_t;
  typedef logic [SUM_W-1:0]          sum_t;
  typedef logic [RHS_W-1:0]          rhs_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic [Q_W-1:0]            quo_t;
  typedef logic [LEN_W-1:0]          len_t;

endpackage

### design/tfn_front.sv
module tfn_front import tfn_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  input  coord_t ax, ay, az,
  input  coord_t bx, by, bz,
  input  coord_t cx, cy, cz,
  input  len_t   min_length,
  output logic   out_valid,
  output sum_t   out_s,
  output sq_t    out_sq [3],
  output logic   out_neg [3],
  output logic   out_degen
);

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;

  // stage 1: edges
  edge_t e1x_r, e1y_r, e1z_r, e2x_r, e2y_r, e2z_r;
  // stage 2: cross product terms
  prod_t p_r [6];
  // stage 3: cross product, magnitude and sign
  mag_t  mag_r [3];
  logic  neg3_r [3];
  // stage 4: partial squares
  logic [33:0] hh_r [3], hl_r [3], ll_r [3];
  logic  neg4_r [3];
  logic [35:0] mhh_r;
  logic [34:0] mhl_r;
  logic [33:0] mll_r;
  // stage 5: squares
  sq_t   sq5_r [3];
  logic  neg5_r [3];
  sum_t  thr5_r;
  // stage 6: sum of squares
  sq_t   sq6_r [3];
  logic  neg6_r [3];
  sum_t  thr6_r, s6_r;
  // stage 7: threshold test
  sq_t   sq7_r [3];
  logic  neg7_r [3];
  sum_t  s7_r;
  logic  degen7_r;

  cross_t n_nxt [3];
  logic [16:0] mh_lo;
  logic [17:0] len_hi;
  logic [16:0] len_lo;

  assign len_hi = min_length[34:17];
  assign len_lo = min_length[16:0];

  always_comb begin
    n_nxt[0] = CROSS_W'(p_r[0]) - CROSS_W'(p_r[1]);
    n_nxt[1] = CROSS_W'(p_r[2]) - CROSS_W'(p_r[3]);
    n_nxt[2] = CROSS_W'(p_r[4]) - CROSS_W'(p_r[5]);
  end

  assign mh_lo = 17'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; v7_r <= 1'b0;
    end else begin
      v1_r <= in_valid; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
      v5_r <= v4_r; v6_r <= v5_r; v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    e1x_r <= edge_t'(bx) - edge_t'(ax);
    e1y_r <= edge_t'(by) - edge_t'(ay);
    e1z_r <= edge_t'(bz) - edge_t'(az);
    e2x_r <= edge_t'(cx) - edge_t'(ax);
    e2y_r <= edge_t'(cy) - edge_t'(ay);
    e2z_r <= edge_t'(cz) - edge_t'(az);

    p_r[0] <= prod_t'(e1y_r) * prod_t'(e2z_r);
    p_r[1] <= prod_t'(e1z_r) * prod_t'(e2y_r);
    p_r[2] <= prod_t'(e1z_r) * prod_t'(e2x_r);
    p_r[3] <= prod_t'(e1x_r) * prod_t'(e2z_r);
    p_r[4] <= prod_t'(e1x_r) * prod_t'(e2y_r);
    p_r[5] <= prod_t'(e1y_r) * prod_t'(e2x_r);

    for (int i = 0; i < 3; i++) begin
      mag_r[i]  <= n_nxt[i][CROSS_W-1] ? MAG_W'(-n_nxt[i]) : MAG_W'(n_nxt[i]);
      neg3_r[i] <= n_nxt[i][CROSS_W-1];

      // |n| split as hi*2^17 + lo, each 17 bits
      hh_r[i] <= 34'(mag_r[i][33:17]) * 34'(mag_r[i][33:17]);
      hl_r[i] <= 34'(mag_r[i][33:17]) * 34'(mag_r[i][16:0]);
      ll_r[i] <= 34'(mag_r[i][16:0] | mh_lo) * 34'(mag_r[i][16:0]);
      neg4_r[i] <= neg3_r[i];

      sq5_r[i] <= (SQ_W'(hh_r[i]) << 34) + (SQ_W'(hl_r[i]) << 18) + SQ_W'(ll_r[i]);
      neg5_r[i] <= neg4_r[i];

      sq6_r[i]  <= sq5_r[i];
      neg6_r[i] <= neg5_r[i];
      sq7_r[i]  <= sq6_r[i];
      neg7_r[i] <= neg6_r[i];
    end

    mhh_r <= 36'(len_hi) * 36'(len_hi);
    mhl_r <= 35'(len_hi) * 35'(len_lo);
    mll_r <= 34'(len_lo) * 34'(len_lo);
    thr5_r <= (SUM_W'(mhh_r) << 34) + (SUM_W'(mhl_r) << 18) + SUM_W'(mll_r);

    s6_r   <= SUM_W'(sq5_r[0]) + SUM_W'(sq5_r[1]) + SUM_W'(sq5_r[2]);
    thr6_r <= thr5_r;

    s7_r     <= s6_r;
    degen7_r <= (s6_r <= thr6_r);
  end

  assign out_valid = v7_r;
  assign out_s     = s7_r;
  assign out_sq    = sq7_r;
  assign out_neg   = neg7_r;
  assign out_degen = degen7_r;

endmodule

### design/tfn_root_step.sv
// One bit of q = max { q : S*(2q-1)^2 <= n^2 * 2^30 }, tracked incrementally
// as t2s = t^2*S and ts = t*S with t = 2q-1.
module tfn_root_step import tfn_pkg::*; #(
  parameter int unsigned BIT = 0
) (
  input  logic clk,
  input  acc_t t2s,
  input  acc_t ts,
  input  quo_t q,
  input  rhs_t rhs,
  input  sum_t s,
  output acc_t t2s_r,
  output acc_t ts_r,
  output quo_t q_r
);

  acc_t s_ext;
  acc_t trial;
  logic take;

  assign s_ext = acc_t'(s);
  assign trial = t2s + (ts <<< (BIT + 2)) + (s_ext <<< (2 * BIT + 2));
  assign take  = (trial <= acc_t'(rhs));

  always_ff @(posedge clk) begin
    t2s_r <= take ? trial : t2s;
    ts_r  <= take ? ts + (s_ext <<< (BIT + 1)) : ts;
    q_r   <= take ? (q | (quo_t'(1) << BIT)) : q;
  end

endmodule

### design/triangle_face_normal_core.sv
// Triangle face normal: takes one triangle (three Q4.12 vertices) per clock
// and returns the unit normal in Q1.14 plus a degenerate flag. busy is always
// low, so start may be held high every cycle. Each request yields exactly one
// result on out_strobe: 7 stages form the edges, the cross product, its
// squared length and the threshold test, then 15 stages resolve one bit of
// each component per cycle, then an output register. Results cannot be held
// off. cfg_wr_en/cfg_wr_data set min_length (reset 17); write it only while
// no request is in flight.
module triangle_face_normal_core import tfn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic signed [15:0] in_ax,
  input  logic signed [15:0] in_ay,
  input  logic signed [15:0] in_az,
  input  logic signed [15:0] in_bx,
  input  logic signed [15:0] in_by,
  input  logic signed [15:0] in_bz,
  input  logic signed [15:0] in_cx,
  input  logic signed [15:0] in_cy,
  input  logic signed [15:0] in_cz,
  input  logic        cfg_wr_en,
  input  logic [34:0] cfg_wr_data,
  output logic        out_strobe,
  output logic signed [15:0] out_norm_x,
  output logic signed [15:0] out_norm_y,
  output logic signed [15:0] out_norm_z,
  output logic        out_degenerate
);

  len_t min_length_r;

  logic f_valid;
  sum_t f_s;
  sq_t  f_sq [3];
  logic f_neg [3];
  logic f_degen;

  logic valid_r [NUM_STEPS+1];
  sum_t s_r     [NUM_STEPS+1];
  rhs_t rhs_r   [3][NUM_STEPS+1];
  logic neg_r   [3][NUM_STEPS+1];
  logic degen_r [NUM_STEPS+1];
  acc_t t2s_w   [3][NUM_STEPS+1];
  acc_t ts_w    [3][NUM_STEPS+1];
  quo_t q_w     [3][NUM_STEPS+1];

  logic strobe_r;
  logic signed [15:0] norm_r [3];
  logic degen_out_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_length_r <= LEN_RESET;
    end else if (cfg_wr_en) begin
      min_length_r <= cfg_wr_data;
    end
  end

  tfn_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (start & ~busy),
    .ax         (in_ax), .ay (in_ay), .az (in_az),
    .bx         (in_bx), .by (in_by), .bz (in_bz),
    .cx         (in_cx), .cy (in_cy), .cz (in_cz),
    .min_length (min_length_r),
    .out_valid  (f_valid),
    .out_s      (f_s),
    .out_sq     (f_sq),
    .out_neg    (f_neg),
    .out_degen  (f_degen)
  );

  assign valid_r[0] = f_valid;
  assign s_r[0]     = f_s;
  assign degen_r[0] = f_degen;

  genvar c, j;
  generate
    for (c = 0; c < 3; c++) begin : g_comp
      // start from q = 0, i.e. t = -1
      assign rhs_r[c][0] = {f_sq[c], 30'd0};
      assign neg_r[c][0] = f_neg[c];
      assign t2s_w[c][0] = acc_t'(f_s);
      assign ts_w[c][0]  = -acc_t'(f_s);
      assign q_w[c][0]   = '0;

      for (j = 0; j < NUM_STEPS; j++) begin : g_step
        tfn_root_step #(.BIT(NUM_STEPS - 1 - j)) u_step (
          .clk   (clk),
          .t2s   (t2s_w[c][j]),
          .ts    (ts_w[c][j]),
          .q     (q_w[c][j]),
          .rhs   (rhs_r[c][j]),
          .s     (s_r[j]),
          .t2s_r (t2s_w[c][j+1]),
          .ts_r  (ts_w[c][j+1]),
          .q_r   (q_w[c][j+1])
        );

        always_ff @(posedge clk) begin
          rhs_r[c][j+1] <= rhs_r[c][j];
          neg_r[c][j+1] <= neg_r[c][j];
        end
      end
    end

    for (j = 0; j < NUM_STEPS; j++) begin : g_side
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          valid_r[j+1] <= 1'b0;
        end else begin
          valid_r[j+1] <= valid_r[j];
        end
      end

      always_ff @(posedge clk) begin
        s_r[j+1]     <= s_r[j];
        degen_r[j+1] <= degen_r[j];
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= valid_r[NUM_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (degen_r[NUM_STEPS]) begin
        norm_r[i] <= '0;
      end else if (neg_r[i][NUM_STEPS]) begin
        norm_r[i] <= -$signed({1'b0, q_w[i][NUM_STEPS]});
      end else begin
        norm_r[i] <= $signed({1'b0, q_w[i][NUM_STEPS]});
      end
    end
    degen_out_r <= degen_r[NUM_STEPS];
  end

  assign out_strobe     = strobe_r;
  assign out_norm_x     = norm_r[0];
  assign out_norm_y     = norm_r[1];
  assign out_norm_z     = norm_r[2];
  assign out_degenerate = degen_out_r;

endmodule

### design/tfn_checker.sv
module tfn_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe,
  input logic signed [15:0] out_norm_x,
  input logic signed [15:0] out_norm_y,
  input logic signed [15:0] out_norm_z,
  input logic out_degenerate
);

  a_request_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##23 out_strobe)
    else $error("request produced no result");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##23 !out_strobe)
    else $error("result without request");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_degenerate) |->
      (out_norm_x == 16'sd0 && out_norm_y == 16'sd0 && out_norm_z == 16'sd0))
    else $error("degenerate result with nonzero normal");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |->
      (out_norm_x <= 16'sd16384 && out_norm_x >= -16'sd16384 &&
       out_norm_y <= 16'sd16384 && out_norm_y >= -16'sd16384 &&
       out_norm_z <= 16'sd16384 && out_norm_z >= -16'sd16384))
    else $error("normal component out of range");

endmodule

bind triangle_face_normal_core tfn_checker u_tfn_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_strobe     (out_strobe),
  .out_norm_x     (out_norm_x),
  .out_norm_y     (out_norm_y),
  .out_norm_z     (out_norm_z),
  .out_degenerate (out_degenerate)
);
